[rtl/vmx_pkg.sv]
// shared types and constants of the interpreter execute unit
`timescale 1ns / 1ps
`default_nettype none
package vmx_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] opcode;
    logic [7:0]  random_byte;
    logic [15:0] key_states;
    logic [11:0] addr;
    logic [7:0]  wr_data;
  } in_item_t;

  typedef struct packed {
    logic [11:0] prog_counter;
    logic [15:0] index_value;
    logic [7:0]  flag_reg;
    logic [7:0]  read_data;
    logic        screen_changed;
    logic        key_wait;
    logic [7:0]  sound_level;
  } out_item_t;

  typedef enum logic [1:0] {
    REQ_EXEC  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_PIXEL = 2'd3
  } req_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_RDX, ST_RDY, ST_EXEC, ST_CLR, ST_MOD, ST_REQ, ST_RWAIT,
    ST_MODX, ST_MODY, ST_DROW, ST_DBYTE, ST_DPIX, ST_DPWAIT, ST_BCD, ST_STORE,
    ST_LDRD, ST_LDWR, ST_DONE
  } state_t;

  // opcode groups (top nibble)
  localparam logic [3:0] OP_SYS   = 4'h0;
  localparam logic [3:0] OP_JP    = 4'h1;
  localparam logic [3:0] OP_CALL  = 4'h2;
  localparam logic [3:0] OP_SEK   = 4'h3;
  localparam logic [3:0] OP_SNEK  = 4'h4;
  localparam logic [3:0] OP_SE    = 4'h5;
  localparam logic [3:0] OP_LDK   = 4'h6;
  localparam logic [3:0] OP_ADDK  = 4'h7;
  localparam logic [3:0] OP_ALU   = 4'h8;
  localparam logic [3:0] OP_SNE   = 4'h9;
  localparam logic [3:0] OP_LDI   = 4'hA;
  localparam logic [3:0] OP_JPV0  = 4'hB;
  localparam logic [3:0] OP_RND   = 4'hC;
  localparam logic [3:0] OP_DRW   = 4'hD;
  localparam logic [3:0] OP_KEY   = 4'hE;
  localparam logic [3:0] OP_MISC  = 4'hF;

  localparam logic [15:0] OPW_CLS = 16'h00E0;
  localparam logic [15:0] OPW_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] MISC_GDT  = 8'h07;
  localparam logic [7:0] MISC_WKEY = 8'h0A;
  localparam logic [7:0] MISC_SDT  = 8'h15;
  localparam logic [7:0] MISC_SST  = 8'h18;
  localparam logic [7:0] MISC_ADDI = 8'h1E;
  localparam logic [7:0] MISC_FONT = 8'h29;
  localparam logic [7:0] MISC_BCD  = 8'h33;
  localparam logic [7:0] MISC_STR  = 8'h55;
  localparam logic [7:0] MISC_LDR  = 8'h65;

  localparam int KEY_COUNT = 16;
  localparam logic [3:0] VF = 4'hF;
  localparam logic [11:0] PC_RESET = 12'h200;
  localparam logic [11:0] FONT_RESET = 12'd80;
  // address reduction walks shifted copies of the memory size from 2^5 down
  localparam logic [2:0] MOD_TOP = 3'd5;

endpackage
`default_nettype wire

[rtl/vmx_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module vmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/vm_instruction_execute_unit_top.sv]
// top level of the interpreter execute unit: sequencer, registers, memory and screen
// plain opcodes pass through register reads and execute; memory requests and memory opcodes first
// reduce the address modulo the memory size, then handle one byte at a time; draw reads a sprite byte
// per row and read-modify-writes each set pixel, and clear sweeps every pixel of the screen
// one item at a time, busy is high until the result strobe, the receiver cannot stall
// after reset the whole screen is swept clear before start is taken
`timescale 1ns / 1ps
`default_nettype none
module vm_instruction_execute_unit_top #(
  parameter int SCREEN_W    = 64,
  parameter int SCREEN_H    = 32,
  parameter int MEM_BYTES   = 4096,
  parameter int STACK_DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire vmx_pkg::in_item_t in_item,
  output logic                   out_valid,
  output vmx_pkg::out_item_t     out_item,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  localparam int PIXELS = SCREEN_W * SCREEN_H;
  localparam int PW  = $clog2(PIXELS);
  localparam int AW  = $clog2(MEM_BYTES);
  localparam int SPW = $clog2(STACK_DEPTH);

  vmx_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  vmx_pkg::in_item_t item_r, item_nxt;
  logic [7:0]  gp_r [16];
  logic [7:0]  gp_nxt [16];
  logic [11:0] stk_r [STACK_DEPTH];
  logic [11:0] stk_nxt [STACK_DEPTH];
  logic [15:0] idx_r, idx_nxt;
  logic [11:0] pc_r, pc_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [7:0]  dly_r, dly_nxt, snd_r, snd_nxt;
  logic [11:0] font_r;
  logic [7:0]  vx_r, vx_nxt, vy_r, vy_nxt;
  logic [7:0]  rd_r, rd_nxt;
  logic        chg_r, chg_nxt, wait_r, wait_nxt;
  logic [15:0] mv_r, mv_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [PW-1:0] clr_r, clr_nxt;
  logic [7:0]  xm_r, xm_nxt, ym_r, ym_nxt;
  logic [3:0]  row_r, row_nxt, col_r, col_nxt, cnt_r, cnt_nxt, dig_r, dig_nxt;
  logic [7:0]  bits_r, bits_nxt, val_r, val_nxt;
  logic [1:0]  ph_r, ph_nxt;

  logic [3:0]  opx, opy, opn, opg, gp_ra;
  logic [7:0]  kk, gp_rd;
  logic [11:0] nnn, pc2, pc4;
  logic [SPW-1:0] sp_inc, sp_dec;
  logic [AW-1:0] ma, ma_inc;
  logic [31:0] mod_sub;
  logic        key_down, any_key, mod_ge;
  logic [3:0]  low_key;
  logic [8:0]  sum9;
  logic [PW-1:0] pix_p, req_pix;
  logic        req_pix_ok;
  logic        mem_we, fb_we, fb_wd, fb_rd;
  logic [7:0]  mem_wd, mem_rd;
  logic [PW-1:0] fb_wa, fb_ra;

  assign opx = item_r.opcode[11:8];
  assign opy = item_r.opcode[7:4];
  assign opn = item_r.opcode[3:0];
  assign opg = item_r.opcode[15:12];
  assign kk  = item_r.opcode[7:0];
  assign nnn = item_r.opcode[11:0];
  assign pc2 = pc_r + 12'd2;
  assign pc4 = pc_r + 12'd4;
  assign sp_inc = (sp_r == SPW'(STACK_DEPTH - 1)) ? '0 : sp_r + SPW'(1);
  assign sp_dec = (sp_r == '0) ? SPW'(STACK_DEPTH - 1) : sp_r - SPW'(1);
  assign ma = mv_r[AW-1:0];
  assign ma_inc = (ma == AW'(MEM_BYTES - 1)) ? '0 : ma + AW'(1);
  assign mod_sub = 32'(MEM_BYTES) << k_r;
  assign mod_ge = 32'(mv_r) >= mod_sub;
  assign key_down = (vx_r < 8'(vmx_pkg::KEY_COUNT)) && item_r.key_states[vx_r[3:0]];
  assign sum9 = {1'b0, vx_r} + {1'b0, vy_r};
  assign pix_p = PW'((32'(ym_r) + 32'(row_r)) * SCREEN_W + 32'(xm_r) + 32'(col_r));
  assign req_pix_ok = 32'(item_r.addr) < PIXELS;
  assign req_pix = PW'(32'(item_r.addr));
  assign gp_rd = gp_r[gp_ra];

  // lowest pressed key
  always_comb begin
    any_key = 1'b0;
    low_key = '0;
    for (int i = vmx_pkg::KEY_COUNT - 1; i >= 0; i--) begin
      if (item_r.key_states[i]) begin
        any_key = 1'b1;
        low_key = 4'(i);
      end
    end
  end

  always_comb begin
    case (state_r)
      vmx_pkg::ST_RDY:   gp_ra = (opg == vmx_pkg::OP_JPV0) ? 4'd0 : opy;
      vmx_pkg::ST_STORE: gp_ra = cnt_r;
      default:           gp_ra = opx;
    endcase
  end

  assign busy = state_r != vmx_pkg::ST_IDLE;
  assign out_valid = state_r == vmx_pkg::ST_DONE;
  assign out_item.prog_counter = pc_r;
  assign out_item.index_value = idx_r;
  assign out_item.flag_reg = gp_r[vmx_pkg::VF];
  assign out_item.read_data = rd_r;
  assign out_item.screen_changed = chg_r;
  assign out_item.key_wait = wait_r;
  assign out_item.sound_level = snd_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {20'd0, font_r} : 32'd0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vmx_pkg::ST_INIT:
        if (clr_r == PW'(PIXELS - 1)) state_nxt = vmx_pkg::ST_IDLE;
      vmx_pkg::ST_CLR:
        if (clr_r == PW'(PIXELS - 1)) state_nxt = vmx_pkg::ST_DONE;
      vmx_pkg::ST_IDLE:
        if (start) begin
          state_nxt = (in_item.req_type == vmx_pkg::REQ_EXEC) ? vmx_pkg::ST_RDX
                                                               : vmx_pkg::ST_MOD;
        end
      vmx_pkg::ST_RDX: state_nxt = vmx_pkg::ST_RDY;
      vmx_pkg::ST_RDY: state_nxt = vmx_pkg::ST_EXEC;
      vmx_pkg::ST_EXEC: begin
        state_nxt = vmx_pkg::ST_DONE;
        if (item_r.opcode == vmx_pkg::OPW_CLS) state_nxt = vmx_pkg::ST_CLR;
        else if (opg == vmx_pkg::OP_DRW) state_nxt = vmx_pkg::ST_MODX;
        else if (opg == vmx_pkg::OP_MISC && (kk == vmx_pkg::MISC_BCD ||
                 kk == vmx_pkg::MISC_STR || kk == vmx_pkg::MISC_LDR))
          state_nxt = vmx_pkg::ST_MOD;
      end
      vmx_pkg::ST_MOD:
        if (k_r == '0) state_nxt = ret_r;
      vmx_pkg::ST_REQ: begin
        if (item_r.req_type == vmx_pkg::REQ_READ ||
            (item_r.req_type == vmx_pkg::REQ_PIXEL && req_pix_ok))
          state_nxt = vmx_pkg::ST_RWAIT;
        else
          state_nxt = vmx_pkg::ST_DONE;
      end
      vmx_pkg::ST_RWAIT: state_nxt = vmx_pkg::ST_DONE;
      vmx_pkg::ST_MODX:
        if (xm_r < 8'(SCREEN_W)) state_nxt = vmx_pkg::ST_MODY;
      vmx_pkg::ST_MODY:
        if (ym_r < 8'(SCREEN_H)) state_nxt = vmx_pkg::ST_MOD;
      vmx_pkg::ST_DROW:
        if (row_r < opn && 32'(ym_r) + 32'(row_r) < SCREEN_H) state_nxt = vmx_pkg::ST_DBYTE;
        else state_nxt = vmx_pkg::ST_DONE;
      vmx_pkg::ST_DBYTE: state_nxt = vmx_pkg::ST_DPIX;
      vmx_pkg::ST_DPIX:
        if (col_r < 4'd8 && 32'(xm_r) + 32'(col_r) < SCREEN_W) begin
          if (bits_r[7]) state_nxt = vmx_pkg::ST_DPWAIT;
        end else begin
          state_nxt = vmx_pkg::ST_DROW;
        end
      vmx_pkg::ST_DPWAIT: state_nxt = vmx_pkg::ST_DPIX;
      vmx_pkg::ST_BCD:
        if (ph_r == 2'd2) state_nxt = vmx_pkg::ST_DONE;
      vmx_pkg::ST_STORE:
        if (cnt_r == opx) state_nxt = vmx_pkg::ST_DONE;
      vmx_pkg::ST_LDRD: state_nxt = vmx_pkg::ST_LDWR;
      vmx_pkg::ST_LDWR:
        state_nxt = (cnt_r == opx) ? vmx_pkg::ST_DONE : vmx_pkg::ST_LDRD;
      vmx_pkg::ST_DONE: state_nxt = vmx_pkg::ST_IDLE;
      default: state_nxt = vmx_pkg::ST_IDLE;
    endcase
  end

  // datapath and ram controls
  always_comb begin
    item_nxt = item_r;
    ret_nxt = ret_r;
    gp_nxt = gp_r;
    stk_nxt = stk_r;
    idx_nxt = idx_r;
    pc_nxt = pc_r;
    sp_nxt = sp_r;
    dly_nxt = dly_r;
    snd_nxt = snd_r;
    vx_nxt = vx_r;
    vy_nxt = vy_r;
    rd_nxt = rd_r;
    chg_nxt = chg_r;
    wait_nxt = wait_r;
    mv_nxt = mv_r;
    k_nxt = k_r;
    clr_nxt = clr_r;
    xm_nxt = xm_r;
    ym_nxt = ym_r;
    row_nxt = row_r;
    col_nxt = col_r;
    cnt_nxt = cnt_r;
    dig_nxt = dig_r;
    bits_nxt = bits_r;
    val_nxt = val_r;
    ph_nxt = ph_r;
    mem_we = 1'b0;
    mem_wd = item_r.wr_data;
    fb_we = 1'b0;
    fb_wa = pix_p;
    fb_wd = ~fb_rd;
    fb_ra = pix_p;
    case (state_r)
      vmx_pkg::ST_INIT, vmx_pkg::ST_CLR: begin
        fb_we = 1'b1;
        fb_wa = clr_r;
        fb_wd = 1'b0;
        clr_nxt = clr_r + PW'(1);
      end
      vmx_pkg::ST_IDLE:
        if (start) begin
          item_nxt = in_item;
          rd_nxt = '0;
          chg_nxt = 1'b0;
          wait_nxt = 1'b0;
          mv_nxt = {4'd0, in_item.addr};
          k_nxt = vmx_pkg::MOD_TOP;
          ret_nxt = vmx_pkg::ST_REQ;
        end
      vmx_pkg::ST_RDX: vx_nxt = gp_rd;
      vmx_pkg::ST_RDY: vy_nxt = gp_rd;
      vmx_pkg::ST_EXEC: begin
        pc_nxt = pc2;
        k_nxt = vmx_pkg::MOD_TOP;
        mv_nxt = idx_r;
        cnt_nxt = '0;
        case (opg)
          vmx_pkg::OP_SYS:
            if (item_r.opcode == vmx_pkg::OPW_CLS) begin
              clr_nxt = '0;
              chg_nxt = 1'b1;
            end else if (item_r.opcode == vmx_pkg::OPW_RET) begin
              sp_nxt = sp_dec;
              pc_nxt = stk_r[sp_dec];
            end
          vmx_pkg::OP_JP: pc_nxt = nnn;
          vmx_pkg::OP_CALL: begin
            stk_nxt[sp_r] = pc2;
            sp_nxt = sp_inc;
            pc_nxt = nnn;
          end
          vmx_pkg::OP_SEK:  if (vx_r == kk) pc_nxt = pc4;
          vmx_pkg::OP_SNEK: if (vx_r != kk) pc_nxt = pc4;
          vmx_pkg::OP_SE:   if (vx_r == vy_r) pc_nxt = pc4;
          vmx_pkg::OP_SNE:  if (vx_r != vy_r) pc_nxt = pc4;
          vmx_pkg::OP_LDK:  gp_nxt[opx] = kk;
          vmx_pkg::OP_ADDK: gp_nxt[opx] = vx_r + kk;
          vmx_pkg::OP_ALU:
            case (opn)
              vmx_pkg::ALU_MOV: gp_nxt[opx] = vy_r;
              vmx_pkg::ALU_OR:  gp_nxt[opx] = vx_r | vy_r;
              vmx_pkg::ALU_AND: gp_nxt[opx] = vx_r & vy_r;
              vmx_pkg::ALU_XOR: gp_nxt[opx] = vx_r ^ vy_r;
              vmx_pkg::ALU_ADD: begin
                gp_nxt[opx] = sum9[7:0];
                gp_nxt[vmx_pkg::VF] = {7'd0, sum9[8]};
              end
              vmx_pkg::ALU_SUB: begin
                gp_nxt[opx] = vx_r - vy_r;
                gp_nxt[vmx_pkg::VF] = {7'd0, vx_r > vy_r};
              end
              vmx_pkg::ALU_SHR: begin
                gp_nxt[opx] = vx_r >> 1;
                gp_nxt[vmx_pkg::VF] = {7'd0, vx_r[0]};
              end
              vmx_pkg::ALU_SUBN: begin
                gp_nxt[opx] = vy_r - vx_r;
                gp_nxt[vmx_pkg::VF] = {7'd0, vy_r > vx_r};
              end
              vmx_pkg::ALU_SHL: begin
                gp_nxt[opx] = vx_r << 1;
                gp_nxt[vmx_pkg::VF] = {7'd0, vx_r[7]};
              end
              default: ;
            endcase
          vmx_pkg::OP_LDI:  idx_nxt = {4'd0, nnn};
          vmx_pkg::OP_JPV0: pc_nxt = nnn + {4'd0, vy_r};
          vmx_pkg::OP_RND:  gp_nxt[opx] = item_r.random_byte & kk;
          vmx_pkg::OP_DRW: begin
            gp_nxt[vmx_pkg::VF] = '0;
            chg_nxt = 1'b1;
            xm_nxt = vx_r;
            ym_nxt = vy_r;
            row_nxt = '0;
            ret_nxt = vmx_pkg::ST_DROW;
          end
          vmx_pkg::OP_KEY:
            if ((kk == vmx_pkg::KEY_SKP && key_down) || (kk == vmx_pkg::KEY_SKNP && !key_down))
              pc_nxt = pc4;
          vmx_pkg::OP_MISC:
            case (kk)
              vmx_pkg::MISC_GDT: gp_nxt[opx] = dly_r;
              vmx_pkg::MISC_WKEY:
                if (any_key) begin
                  gp_nxt[opx] = {4'd0, low_key};
                end else begin
                  pc_nxt = pc_r;
                  wait_nxt = 1'b1;
                end
              vmx_pkg::MISC_SDT:  dly_nxt = vx_r;
              vmx_pkg::MISC_SST:  snd_nxt = vx_r;
              vmx_pkg::MISC_ADDI: idx_nxt = idx_r + {8'd0, vx_r};
              vmx_pkg::MISC_FONT: idx_nxt = {4'd0, font_r} + 16'(vx_r[3:0]) * 16'd5;
              vmx_pkg::MISC_BCD: begin
                val_nxt = vx_r;
                dig_nxt = '0;
                ph_nxt = '0;
                ret_nxt = vmx_pkg::ST_BCD;
              end
              vmx_pkg::MISC_STR: ret_nxt = vmx_pkg::ST_STORE;
              vmx_pkg::MISC_LDR: ret_nxt = vmx_pkg::ST_LDRD;
              default: ;
            endcase
          default: ;
        endcase
      end
      vmx_pkg::ST_MOD: begin
        // restoring reduction by shifted copies of the memory size
        if (mod_ge) mv_nxt = 16'(32'(mv_r) - mod_sub);
        k_nxt = k_r - 3'd1;
      end
      vmx_pkg::ST_REQ: begin
        fb_ra = req_pix;
        if (item_r.req_type == vmx_pkg::REQ_WRITE) mem_we = 1'b1;
      end
      vmx_pkg::ST_RWAIT:
        rd_nxt = (item_r.req_type == vmx_pkg::REQ_READ) ? mem_rd : {7'd0, fb_rd};
      vmx_pkg::ST_MODX: if (xm_r >= 8'(SCREEN_W)) xm_nxt = xm_r - 8'(SCREEN_W);
      vmx_pkg::ST_MODY: if (ym_r >= 8'(SCREEN_H)) ym_nxt = ym_r - 8'(SCREEN_H);
      vmx_pkg::ST_DBYTE: begin
        bits_nxt = mem_rd;
        col_nxt = '0;
        row_nxt = row_r + 4'd1;
        mv_nxt = 16'(ma_inc);
      end
      vmx_pkg::ST_DPIX: begin
        // row has already been advanced, so point back at the row in work
        fb_ra = PW'((32'(ym_r) + 32'(row_r) - 32'd1) * SCREEN_W + 32'(xm_r) + 32'(col_r));
        if (!bits_r[7]) begin
          bits_nxt = bits_r << 1;
          col_nxt = col_r + 4'd1;
        end
      end
      vmx_pkg::ST_DPWAIT: begin
        fb_we = 1'b1;
        fb_wa = PW'((32'(ym_r) + 32'(row_r) - 32'd1) * SCREEN_W + 32'(xm_r) + 32'(col_r));
        if (fb_rd) gp_nxt[vmx_pkg::VF] = 8'd1;
        bits_nxt = bits_r << 1;
        col_nxt = col_r + 4'd1;
      end
      vmx_pkg::ST_BCD:
        case (ph_r)
          2'd0:
            if (val_r >= 8'd100) begin
              val_nxt = val_r - 8'd100;
              dig_nxt = dig_r + 4'd1;
            end else begin
              mem_we = 1'b1;
              mem_wd = {4'd0, dig_r};
              mv_nxt = 16'(ma_inc);
              dig_nxt = '0;
              ph_nxt = 2'd1;
            end
          2'd1:
            if (val_r >= 8'd10) begin
              val_nxt = val_r - 8'd10;
              dig_nxt = dig_r + 4'd1;
            end else begin
              mem_we = 1'b1;
              mem_wd = {4'd0, dig_r};
              mv_nxt = 16'(ma_inc);
              ph_nxt = 2'd2;
            end
          default: begin
            mem_we = 1'b1;
            mem_wd = val_r;
          end
        endcase
      vmx_pkg::ST_STORE: begin
        mem_we = 1'b1;
        mem_wd = gp_rd;
        cnt_nxt = cnt_r + 4'd1;
        mv_nxt = 16'(ma_inc);
      end
      vmx_pkg::ST_LDWR: begin
        gp_nxt[cnt_r] = mem_rd;
        cnt_nxt = cnt_r + 4'd1;
        mv_nxt = 16'(ma_inc);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vmx_pkg::ST_INIT;
      clr_r <= '0;
      idx_r <= '0;
      pc_r <= vmx_pkg::PC_RESET;
      sp_r <= '0;
      dly_r <= '0;
      snd_r <= '0;
      font_r <= vmx_pkg::FONT_RESET;
      for (int i = 0; i < 16; i++) gp_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      idx_r <= idx_nxt;
      pc_r <= pc_nxt;
      sp_r <= sp_nxt;
      dly_r <= dly_nxt;
      snd_r <= snd_nxt;
      gp_r <= gp_nxt;
      if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
        font_r <= pwdata[11:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    ret_r <= ret_nxt;
    stk_r <= stk_nxt;
    vx_r <= vx_nxt;
    vy_r <= vy_nxt;
    rd_r <= rd_nxt;
    chg_r <= chg_nxt;
    wait_r <= wait_nxt;
    mv_r <= mv_nxt;
    k_r <= k_nxt;
    xm_r <= xm_nxt;
    ym_r <= ym_nxt;
    row_r <= row_nxt;
    col_r <= col_nxt;
    cnt_r <= cnt_nxt;
    dig_r <= dig_nxt;
    bits_r <= bits_nxt;
    val_r <= val_nxt;
    ph_r <= ph_nxt;
  end

  vmx_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ma),
    .wdata (mem_wd),
    .raddr (ma),
    .rdata (mem_rd)
  );

  vmx_ram #(.WIDTH(1), .DEPTH(PIXELS)) u_frame (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_wa),
    .wdata (fb_wd),
    .raddr (fb_ra),
    .rdata (fb_rd)
  );

  // draw pixel index before the row advance is only used through the adjusted form
  logic unused_pix;
  assign unused_pix = ^pix_p;
endmodule
`default_nettype wire

[verif/vm_instruction_execute_unit_top_test.sv]
// self-checking testbench of the interpreter execute unit: directed items and table, then random items
`timescale 1ns / 1ps
module vm_instruction_execute_unit_top_test;
  import vmx_pkg::*;

  localparam int PIXELS   = 64 * 32;
  localparam int MEM_SIZE = 4096;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  vm_instruction_execute_unit_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // machine state as the predictor sees it
  logic [7:0]  vreg [16];
  logic [15:0] idx_reg;
  logic [11:0] pc;
  logic [3:0]  sp;
  logic [11:0] ret_stack [16];
  bit          ret_ok [16];
  logic [7:0]  delay_t, sound_t;
  logic [7:0]  mem [MEM_SIZE];
  bit          pix [PIXELS];
  logic [11:0] font_addr;

  out_item_t   pending_results [$];
  stim_row_t   table_rows [$];
  int          errors;
  int          cycles;
  int          idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("vm_instruction_execute_unit_top verification failed");
      $finish;
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        out_item_t w;
        w = pending_results.pop_front();
        check_field("prog_counter", w.prog_counter, out_item.prog_counter);
        check_field("index_value", w.index_value, out_item.index_value);
        check_field("flag_reg", w.flag_reg, out_item.flag_reg);
        check_field("read_data", w.read_data, out_item.read_data);
        check_field("screen_changed", w.screen_changed, out_item.screen_changed);
        check_field("key_wait", w.key_wait, out_item.key_wait);
        check_field("sound_level", w.sound_level, out_item.sound_level);
      end
    end
  end

  function automatic void clear_state();
    for (int i = 0; i < 16; i++) begin
      vreg[i] = '0;
      ret_stack[i] = '0;
      ret_ok[i] = 0;
    end
    for (int i = 0; i < PIXELS; i++) pix[i] = 0;
    for (int i = 0; i < MEM_SIZE; i++) mem[i] = '0;
    idx_reg = '0;
    pc = PC_RESET;
    sp = '0;
    delay_t = '0;
    sound_t = '0;
    font_addr = FONT_RESET;
  endfunction

  function automatic void draw_sprite(logic [3:0] x, logic [3:0] y, logic [3:0] n);
    int x0, y0, p;
    logic [7:0] bits;
    x0 = vreg[x] % 64;
    y0 = vreg[y] % 32;
    vreg[VF] = 8'd0;
    for (int r = 0; r < n && y0 + r < 32; r++) begin
      bits = mem[(int'(idx_reg) + r) % MEM_SIZE];
      for (int c = 0; c < 8 && x0 + c < 64; c++) begin
        if (bits[7 - c]) begin
          p = (y0 + r) * 64 + x0 + c;
          if (pix[p]) vreg[VF] = 8'd1;
          pix[p] = ~pix[p];
        end
      end
    end
  endfunction

  function automatic void run_opcode(logic [15:0] op, logic [7:0] rnd, logic [15:0] keys,
                                     ref out_item_t o);
    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy;
    logic [11:0] nnn;
    bit          down;
    int          k;
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    kk = op[7:0];
    nnn = op[11:0];
    pc = pc + 12'd2;
    vx = vreg[x];
    vy = vreg[y];
    case (op[15:12])
      OP_SYS: begin
        if (op == OPW_CLS) begin
          for (int i = 0; i < PIXELS; i++) pix[i] = 0;
          o.screen_changed = 1'b1;
        end else if (op == OPW_RET) begin
          sp = sp - 4'd1;
          pc = ret_stack[sp];
        end
      end
      OP_JP: pc = nnn;
      OP_CALL: begin
        ret_stack[sp] = pc;
        ret_ok[sp] = 1;
        sp = sp + 4'd1;
        pc = nnn;
      end
      OP_SEK:  if (vx == kk) pc = pc + 12'd2;
      OP_SNEK: if (vx != kk) pc = pc + 12'd2;
      OP_SE:   if (vx == vy) pc = pc + 12'd2;
      OP_LDK:  vreg[x] = kk;
      OP_ADDK: vreg[x] = vx + kk;
      OP_ALU: begin
        case (n)
          ALU_MOV: vreg[x] = vy;
          ALU_OR:  vreg[x] = vx | vy;
          ALU_AND: vreg[x] = vx & vy;
          ALU_XOR: vreg[x] = vx ^ vy;
          ALU_ADD: begin
            vreg[x] = vx + vy;
            vreg[VF] = (int'(vx) + int'(vy) > 255) ? 8'd1 : 8'd0;
          end
          ALU_SUB: begin
            vreg[x] = vx - vy;
            vreg[VF] = (vx > vy) ? 8'd1 : 8'd0;
          end
          ALU_SHR: begin
            vreg[x] = vx >> 1;
            vreg[VF] = {7'd0, vx[0]};
          end
          ALU_SUBN: begin
            vreg[x] = vy - vx;
            vreg[VF] = (vy > vx) ? 8'd1 : 8'd0;
          end
          ALU_SHL: begin
            vreg[x] = vx << 1;
            vreg[VF] = {7'd0, vx[7]};
          end
          default: ;
        endcase
      end
      OP_SNE:  if (vx != vy) pc = pc + 12'd2;
      OP_LDI:  idx_reg = {4'd0, nnn};
      OP_JPV0: pc = nnn + {4'd0, vreg[0]};
      OP_RND:  vreg[x] = rnd & kk;
      OP_DRW: begin
        draw_sprite(x, y, n);
        o.screen_changed = 1'b1;
      end
      OP_KEY: begin
        down = (vx < KEY_COUNT) && keys[vx[3:0]];
        if ((kk == KEY_SKP && down) || (kk == KEY_SKNP && !down)) pc = pc + 12'd2;
      end
      OP_MISC: begin
        case (kk)
          MISC_GDT: vreg[x] = delay_t;
          MISC_WKEY: begin
            k = -1;
            for (int i = KEY_COUNT - 1; i >= 0; i--) if (keys[i]) k = i;
            if (k >= 0) vreg[x] = 8'(k);
            else begin
              pc = pc - 12'd2;
              o.key_wait = 1'b1;
            end
          end
          MISC_SDT:  delay_t = vx;
          MISC_SST:  sound_t = vx;
          MISC_ADDI: idx_reg = idx_reg + {8'd0, vx};
          MISC_FONT: idx_reg = {4'd0, font_addr} + 16'd5 * {12'd0, vx[3:0]};
          MISC_BCD: begin
            mem[int'(idx_reg) % MEM_SIZE] = vx / 100;
            mem[(int'(idx_reg) + 1) % MEM_SIZE] = (vx / 10) % 10;
            mem[(int'(idx_reg) + 2) % MEM_SIZE] = vx % 10;
          end
          MISC_STR: for (int i = 0; i <= x; i++) mem[(int'(idx_reg) + i) % MEM_SIZE] = vreg[i];
          MISC_LDR: for (int i = 0; i <= x; i++) vreg[i] = mem[(int'(idx_reg) + i) % MEM_SIZE];
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  function automatic out_item_t predict_step(in_item_t it);
    out_item_t o;
    o = '0;
    case (req_t'(it.req_type))
      REQ_EXEC:  run_opcode(it.opcode, it.random_byte, it.key_states, o);
      REQ_WRITE: mem[it.addr] = it.wr_data;
      REQ_READ:  o.read_data = mem[it.addr];
      default:   o.read_data = (it.addr < PIXELS) ? {7'd0, pix[it.addr]} : 8'd0;
    endcase
    o.prog_counter = pc;
    o.index_value = idx_reg;
    o.flag_reg = vreg[VF];
    o.sound_level = sound_t;
    return o;
  endfunction

  // a return into a stack slot that was never pushed becomes a call
  function automatic in_item_t make_legal(in_item_t it);
    if (it.req_type == REQ_EXEC && it.opcode == OPW_RET && !ret_ok[sp - 4'd1])
      it.opcode = {OP_CALL, 12'($urandom)};
    return it;
  endfunction

  task automatic drive_item(in_item_t it, bit typed, out_item_t want);
    out_item_t got;
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    it = make_legal(it);
    in_item = it;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    got = predict_step(it);
    pending_results.push_back(typed ? want : got);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_font(logic [11:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = 3'd0;
    pwdata = {20'd0, value};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    check_field("font_base", value, prdata[11:0]);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    font_addr = value;
  endtask

  function automatic in_item_t mk(logic [1:0] req, logic [15:0] op, logic [7:0] rnd,
                                  logic [15:0] keys, logic [11:0] a, logic [7:0] wd);
    in_item_t it;
    it.req_type = req;
    it.opcode = op;
    it.random_byte = rnd;
    it.key_states = keys;
    it.addr = a;
    it.wr_data = wd;
    return it;
  endfunction

  function automatic void add_row(in_item_t it, bit typed = 0, out_item_t want = '0);
    stim_row_t r;
    r.item = it;
    r.typed = typed;
    r.want = want;
    table_rows.push_back(r);
  endfunction

  function automatic out_item_t ow(logic [11:0] p, logic [7:0] f);
    out_item_t o;
    o = '0;
    o.prog_counter = p;
    o.flag_reg = f;
    return o;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    logic [15:0] op;
    int pick;
    it = in_item_t'({$urandom, $urandom});
    it.key_states = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) it.req_type = REQ_WRITE;
    else if (pick < 15) it.req_type = REQ_READ;
    else if (pick < 22) it.req_type = REQ_PIXEL;
    else it.req_type = REQ_EXEC;
    op = 16'($urandom);
    case (op[15:12])
      OP_SYS: begin
        pick = $urandom_range(0, 99);
        if (pick < 3) op = OPW_CLS;
        else if (pick < 50) op = OPW_RET;
        else if (op == OPW_CLS) op = OPW_RET;
      end
      OP_LDK: if ($urandom_range(0, 1)) op[7:4] = 4'd0;
      OP_ALU: if ($urandom_range(0, 3) != 0) op[3:0] = 4'($urandom_range(0, 7));
      OP_KEY: op[7:0] = $urandom_range(0, 5) == 0 ? op[7:0] :
                        ($urandom_range(0, 1) ? KEY_SKP : KEY_SKNP);
      OP_MISC: begin
        case ($urandom_range(0, 9))
          0: op[7:0] = MISC_GDT;
          1: op[7:0] = MISC_WKEY;
          2: op[7:0] = MISC_SDT;
          3: op[7:0] = MISC_SST;
          4: op[7:0] = MISC_ADDI;
          5: op[7:0] = MISC_FONT;
          6: op[7:0] = MISC_BCD;
          7: op[7:0] = MISC_STR;
          8: op[7:0] = MISC_LDR;
          default: ;
        endcase
      end
      default: ;
    endcase
    it.opcode = op;
    return it;
  endfunction

  initial begin
    in_item_t t;
    errors = 0;
    cycles = 0;
    idle_pct = 33;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    clear_state();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    write_font(12'd80);
    // state right after reset, pixel index in range and then out of range
    drive_item(mk(REQ_PIXEL, 16'h0, 8'h0, 16'h0, 12'd0, 8'h0), 1, ow(PC_RESET, 8'd0));
    drive_item(mk(REQ_PIXEL, 16'hFFFF, 8'hFF, 16'hFFFF, 12'hFFF, 8'hFF), 1,
               ow(PC_RESET, 8'd0));
    // fill the whole memory so that every later load reads a written byte
    for (int i = 0; i < MEM_SIZE; i++)
      drive_item(mk(REQ_WRITE, 16'($urandom), 8'($urandom), 16'($urandom), 12'(i),
                    8'($urandom)), 0, '0);

    add_row(mk(REQ_EXEC, 16'h1FFE, 8'h00, 16'h0, 12'h0, 8'h0), 1, ow(12'hFFE, 8'd0));
    add_row(mk(REQ_EXEC, 16'h6FFF, 8'h00, 16'h0, 12'h0, 8'h0), 1, ow(12'h000, 8'hFF));
    add_row(mk(REQ_EXEC, OPW_CLS, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'hA300, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'h603E, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'h611E, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'hD01F, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'hD01F, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_PIXEL, 16'h0, 8'h00, 16'h0, 12'd1982, 8'h0));
    add_row(mk(REQ_EXEC, 16'h62FF, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'h8F24, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'h8F27, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'h8125, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'h8F26, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'h822E, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'h8123, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'h812F, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'h2ABC, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, OPW_RET, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'hBFFF, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'hC3FF, 8'hA5, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'h6405, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'hE49E, 8'h00, 16'h0020, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'hE4A1, 8'h00, 16'h0020, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'hF50A, 8'h00, 16'h0000, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'hF50A, 8'h00, 16'h8000, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'hF218, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'hF229, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'hF233, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'hF555, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_EXEC, 16'hF565, 8'h00, 16'h0, 12'h0, 8'h0));
    add_row(mk(REQ_READ, 16'h0, 8'h00, 16'h0, 12'hFFF, 8'h0));
    foreach (table_rows[i]) drive_item(table_rows[i].item, table_rows[i].typed,
                                       table_rows[i].want);

    // random phases, each under its own glyph base
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: write_font(12'd0);
        1: write_font(12'hFFF);
        2: write_font(12'($urandom));
        default: write_font(FONT_RESET);
      endcase
      idle_pct = (ph == 1) ? 0 : 33;
      for (int i = 0; i < 150; i++) begin
        t = random_item();
        drive_item(t, 0, '0);
      end
    end

    drain();
    if (errors == 0) $display("vm_instruction_execute_unit_top verification clean");
    else $display("vm_instruction_execute_unit_top verification failed");
    $finish;
  end

endmodule
